// File: hw/rtl/rae_pkg.sv
// Shared types and constants for the register ALU executor.
`default_nettype none

package rae_pkg;

    // Opcode field codes of an incoming item
    localparam logic [3:0] KIND_LOAD = 4'd0;
    localparam logic [3:0] KIND_MOV  = 4'd1;
    localparam logic [3:0] KIND_ADD  = 4'd2;
    localparam logic [3:0] KIND_SUB  = 4'd3;
    localparam logic [3:0] KIND_MUL  = 4'd4;
    localparam logic [3:0] KIND_DIV  = 4'd5;
    localparam logic [3:0] KIND_MOD  = 4'd6;
    localparam logic [3:0] KIND_AND  = 4'd7;
    localparam logic [3:0] KIND_OR   = 4'd8;
    localparam logic [3:0] KIND_XOR  = 4'd9;
    localparam logic [3:0] KIND_XCHG = 4'd10;
    localparam logic [3:0] KIND_OUT  = 4'd11;

    localparam int unsigned IN_TDATA_W = 48;
    localparam int unsigned VALUE_W    = 32;

    typedef enum logic [3:0] {
        OP_LOAD, OP_MOV, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD,
        OP_AND, OP_OR, OP_XOR, OP_XCHG, OP_OUT, OP_NOP
    } t_op;

    // Decoded instruction as held in the queue; indexes already wrapped
    typedef struct packed {
        t_op         op;
        logic [1:0]  d;
        logic [1:0]  ra;
        logic [1:0]  rb;
        logic [31:0] imm;
    } t_inst;

    typedef enum logic [1:0] {
        MDU_MUL, MDU_DIV, MDU_MOD
    } t_mdu_op;

    typedef struct packed {
        logic    start;
        t_mdu_op op;
    } t_mdu_req;

endpackage

`default_nettype wire

// File: hw/rtl/register_alu_executor_core.sv
// Top level of the register ALU executor: front end, queue and back end.
//
//  channel  | direction | signals                        | payload
//  ---------+-----------+--------------------------------+------------------------------
//  s_axis   | in        | s_axis_tvalid / s_axis_tready  | tdata: kind, dest, src_a,
//           |           |                                |   src_b, immediate
//  m_axis   | out       | m_axis_tvalid / m_axis_tready  | tdata: value; tuser: error
//
//  Sequence: IDLE pops an item and registers its register file reads; EXEC runs it;
//  exchange adds SWAP; multiply, and divide and modulo without a fault, wait in MDU
//  for the bit-serial multiply/divide unit (one bit per cycle).
//  Reset: synchronous, active low; it empties the queue, drops any pending
//  result and marks every register as zero.
//  Stalls: a two-entry queue lets the front take items while the back executes;
//  a held result stalls the back end when it has another result to emit.
`default_nettype none

module register_alu_executor_core #(
    parameter int unsigned NUM_REGS   = 4,
    parameter int unsigned DATA_WIDTH = 32
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // [3:0] kind, [5:4] dest, [7:6] src_a, [9:8] src_b, [41:10] immediate,
    // [47:42] zero
    input  wire logic [rae_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // [31:0] value
    output logic [rae_pkg::VALUE_W-1:0]             m_axis_tdata,
    // [0] error
    output logic [0:0]                              m_axis_tuser
);

    logic           w_q_valid, w_q_pop, w_err;
    rae_pkg::t_inst w_q_inst;

    // Decode and queue incoming items
    rae_front #(
        .NUM_REGS (NUM_REGS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_tvalid  (s_axis_tvalid),
        .o_tready  (s_axis_tready),
        .i_tdata   (s_axis_tdata),
        .o_q_valid (w_q_valid),
        .o_q_inst  (w_q_inst),
        .i_q_pop   (w_q_pop)
    );

    // Execute against the register file and hold the result
    rae_back #(
        .NUM_REGS   (NUM_REGS),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_q_inst    (w_q_inst),
        .o_q_pop     (w_q_pop),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_value (m_axis_tdata),
        .o_out_err   (w_err)
    );

    assign m_axis_tuser = w_err;

endmodule

`default_nettype wire

// File: hw/rtl/rae_front.sv
// Front end: accept items, decode them and hold them in a two-entry queue.
`default_nettype none

module rae_front #(
    parameter int unsigned NUM_REGS = 4
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_tvalid,
    output logic                                    o_tready,
    input  wire logic [rae_pkg::IN_TDATA_W-1:0]     i_tdata,
    output logic                                    o_q_valid,
    output rae_pkg::t_inst                          o_q_inst,
    input  wire logic                               i_q_pop
);

    localparam int unsigned Q_DEPTH = 2;

    rae_pkg::t_inst r_q [Q_DEPTH];
    logic           r_wr_ptr, r_rd_ptr;
    logic [1:0]     r_count;
    rae_pkg::t_inst w_inst;
    logic           w_push;

    // Wrap a register index into the file
    function automatic logic [1:0] f_wrap(input logic [1:0] raw);
        if (int'(raw) >= int'(NUM_REGS)) begin
            return 2'(int'(raw) - int'(NUM_REGS));
        end
        return raw;
    endfunction

    always_comb begin
        w_inst.d   = f_wrap(i_tdata[5:4]);
        w_inst.ra  = f_wrap(i_tdata[7:6]);
        w_inst.rb  = f_wrap(i_tdata[9:8]);
        w_inst.imm = i_tdata[41:10];
        case (i_tdata[3:0])
            rae_pkg::KIND_LOAD: w_inst.op = rae_pkg::OP_LOAD;
            rae_pkg::KIND_MOV:  w_inst.op = rae_pkg::OP_MOV;
            rae_pkg::KIND_ADD:  w_inst.op = rae_pkg::OP_ADD;
            rae_pkg::KIND_SUB:  w_inst.op = rae_pkg::OP_SUB;
            rae_pkg::KIND_MUL:  w_inst.op = rae_pkg::OP_MUL;
            rae_pkg::KIND_DIV:  w_inst.op = rae_pkg::OP_DIV;
            rae_pkg::KIND_MOD:  w_inst.op = rae_pkg::OP_MOD;
            rae_pkg::KIND_AND:  w_inst.op = rae_pkg::OP_AND;
            rae_pkg::KIND_OR:   w_inst.op = rae_pkg::OP_OR;
            rae_pkg::KIND_XOR:  w_inst.op = rae_pkg::OP_XOR;
            rae_pkg::KIND_XCHG: begin
                // exchange reads its destination through the second port
                w_inst.op = rae_pkg::OP_XCHG;
                w_inst.rb = f_wrap(i_tdata[5:4]);
            end
            rae_pkg::KIND_OUT:  w_inst.op = rae_pkg::OP_OUT;
            default:            w_inst.op = rae_pkg::OP_NOP;
        endcase
    end

    assign o_tready  = (r_count != 2'(Q_DEPTH));
    assign w_push    = i_tvalid && o_tready;
    assign o_q_valid = (r_count != 2'd0);
    assign o_q_inst  = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_q_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + 2'(w_push) - 2'(i_q_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_inst;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/rae_mdu.sv
// Iterative multiply and signed divide unit, one bit per cycle.
`default_nettype none

module rae_mdu #(
    parameter int unsigned DATA_WIDTH = 32
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire rae_pkg::t_mdu_req      i_req,
    input  wire logic [DATA_WIDTH-1:0]  i_a,
    input  wire logic [DATA_WIDTH-1:0]  i_b,
    output logic                        o_done,
    output logic [DATA_WIDTH-1:0]       o_result
);

    localparam int unsigned DW    = DATA_WIDTH;
    localparam int unsigned CNT_W = $clog2(DATA_WIDTH + 1);

    typedef enum logic [1:0] {M_IDLE, M_RUN, M_FIX} t_mstate;

    t_mstate          r_state, n_state;
    rae_pkg::t_mdu_op r_op, n_op;
    logic [DW-1:0]    r_x, n_x, r_y, n_y, r_acc, n_acc;
    logic [DW-1:0]    r_result, n_result;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_neg_q, n_neg_q, r_neg_r, n_neg_r;
    logic             r_done, n_done;
    logic [DW+1:0]    w_trial;

    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_x      = r_x;
        n_y      = r_y;
        n_acc    = r_acc;
        n_cnt    = r_cnt;
        n_neg_q  = r_neg_q;
        n_neg_r  = r_neg_r;
        n_result = r_result;
        n_done   = 1'b0;
        w_trial  = {1'b0, r_acc, r_x[DW-1]} - {2'b00, r_y};
        case (r_state)
            M_IDLE: begin
                if (i_req.start) begin
                    n_op    = i_req.op;
                    n_acc   = '0;
                    n_cnt   = CNT_W'(DW);
                    n_neg_q = i_a[DW-1] ^ i_b[DW-1];
                    n_neg_r = i_a[DW-1];
                    n_state = M_RUN;
                    if (i_req.op == rae_pkg::MDU_MUL) begin
                        n_x = i_a;
                        n_y = i_b;
                    end else begin
                        n_x = i_a[DW-1] ? (DW'(0) - i_a) : i_a;
                        n_y = i_b[DW-1] ? (DW'(0) - i_b) : i_b;
                    end
                end
            end
            M_RUN: begin
                if (r_op == rae_pkg::MDU_MUL) begin
                    // shift-and-add, low half only
                    n_acc = r_acc + (r_x[0] ? r_y : '0);
                    n_x   = r_x >> 1;
                    n_y   = r_y << 1;
                end else if (!w_trial[DW+1]) begin
                    n_acc = w_trial[DW-1:0];
                    n_x   = {r_x[DW-2:0], 1'b1};
                end else begin
                    n_acc = {r_acc[DW-2:0], r_x[DW-1]};
                    n_x   = {r_x[DW-2:0], 1'b0};
                end
                n_cnt = r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    n_state = M_FIX;
                end
            end
            M_FIX: begin
                case (r_op)
                    rae_pkg::MDU_DIV: n_result = r_neg_q ? (DW'(0) - r_x) : r_x;
                    rae_pkg::MDU_MOD: n_result = r_neg_r ? (DW'(0) - r_acc) : r_acc;
                    default:          n_result = r_acc;
                endcase
                n_done  = 1'b1;
                n_state = M_IDLE;
            end
            default: n_state = M_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_op     <= n_op;
        r_x      <= n_x;
        r_y      <= n_y;
        r_acc    <= n_acc;
        r_cnt    <= n_cnt;
        r_neg_q  <= n_neg_q;
        r_neg_r  <= n_neg_r;
        r_result <= n_result;
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

`default_nettype wire

// File: hw/rtl/rae_back.sv
// Back end: register file, execution sequencer and result register.
`default_nettype none

module rae_back #(
    parameter int unsigned NUM_REGS   = 4,
    parameter int unsigned DATA_WIDTH = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_q_valid,
    input  wire rae_pkg::t_inst                i_q_inst,
    output logic                               o_q_pop,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [rae_pkg::VALUE_W-1:0]        o_out_value,
    output logic                               o_out_err
);

    localparam int unsigned DW    = DATA_WIDTH;
    localparam int unsigned IDX_W = $clog2(NUM_REGS);

    typedef enum logic [2:0] {S_IDLE, S_EXEC, S_SWAP, S_MDU} t_state;

    t_state                      r_state, n_state;
    rae_pkg::t_inst              r_inst;
    logic [DW-1:0]               r_mem [NUM_REGS];
    logic [NUM_REGS-1:0]         r_valid;
    logic [DW-1:0]               r_rd_a, r_rd_b;
    logic                        r_va, r_vb;
    logic                        r_out_valid, n_out_valid;
    logic [rae_pkg::VALUE_W-1:0] r_out_value, n_out_value;
    logic                        r_out_err, n_out_err;
    logic [DW-1:0]               w_a, w_b, w_wdata, w_mdu_res;
    logic [IDX_W-1:0]            w_waddr;
    logic                        w_we, w_out_free, w_fault, w_mdu_done;
    rae_pkg::t_mdu_req           w_mdu_req;

    function automatic logic [IDX_W-1:0] f_idx(input logic [1:0] x);
        return IDX_W'(x);
    endfunction

    function automatic logic [DW-1:0] f_sext_imm(input logic [31:0] v);
        logic [DW-1:0] r;
        for (int i = 0; i < int'(DW); i++) begin
            r[i] = v[(i < 32) ? i : 31];
        end
        return r;
    endfunction

    function automatic logic [rae_pkg::VALUE_W-1:0] f_out_val(input logic [DW-1:0] v);
        logic [rae_pkg::VALUE_W-1:0] r;
        for (int i = 0; i < int'(rae_pkg::VALUE_W); i++) begin
            r[i] = v[(i < int'(DW)) ? i : int'(DW) - 1];
        end
        return r;
    endfunction

    // unwritten entries read as zero
    assign w_a        = r_va ? r_rd_a : '0;
    assign w_b        = r_vb ? r_rd_b : '0;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_fault    = (w_b == '0) ||
                        ((w_a == {1'b1, {(DW-1){1'b0}}}) && (w_b == {DW{1'b1}}));

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_value = r_out_value;
        n_out_err   = r_out_err;
        o_q_pop     = 1'b0;
        w_we        = 1'b0;
        w_waddr     = f_idx(r_inst.d);
        w_wdata     = w_a;
        w_mdu_req   = '{start: 1'b0, op: rae_pkg::MDU_MUL};
        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
                case (r_inst.op)
                    rae_pkg::OP_LOAD: begin
                        w_we = 1'b1; w_wdata = f_sext_imm(r_inst.imm);
                    end
                    rae_pkg::OP_MOV:  w_we = 1'b1;
                    rae_pkg::OP_ADD: begin
                        w_we = 1'b1; w_wdata = w_a + w_b;
                    end
                    rae_pkg::OP_SUB: begin
                        w_we = 1'b1; w_wdata = w_a - w_b;
                    end
                    rae_pkg::OP_AND: begin
                        w_we = 1'b1; w_wdata = w_a & w_b;
                    end
                    rae_pkg::OP_OR: begin
                        w_we = 1'b1; w_wdata = w_a | w_b;
                    end
                    rae_pkg::OP_XOR: begin
                        w_we = 1'b1; w_wdata = w_a ^ w_b;
                    end
                    rae_pkg::OP_XCHG: begin
                        w_we    = 1'b1;
                        n_state = S_SWAP;
                    end
                    rae_pkg::OP_MUL: begin
                        w_mdu_req = '{start: 1'b1, op: rae_pkg::MDU_MUL};
                        n_state   = S_MDU;
                    end
                    rae_pkg::OP_DIV, rae_pkg::OP_MOD: begin
                        if (!w_fault) begin
                            w_mdu_req.start = 1'b1;
                            w_mdu_req.op    = (r_inst.op == rae_pkg::OP_DIV) ?
                                              rae_pkg::MDU_DIV : rae_pkg::MDU_MOD;
                            n_state         = S_MDU;
                        end else if (w_out_free) begin
                            n_out_valid = 1'b1;
                            n_out_value = '0;
                            n_out_err   = 1'b1;
                        end else begin
                            n_state = S_EXEC;
                        end
                    end
                    rae_pkg::OP_OUT: begin
                        if (w_out_free) begin
                            n_out_valid = 1'b1;
                            n_out_value = f_out_val(w_a);
                            n_out_err   = 1'b0;
                        end else begin
                            n_state = S_EXEC;
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_SWAP: begin
                // second half of the exchange: partner gets the old destination
                w_we    = 1'b1;
                w_waddr = f_idx(r_inst.ra);
                w_wdata = w_b;
                n_state = S_IDLE;
            end
            S_MDU: begin
                if (w_mdu_done) begin
                    w_we    = 1'b1;
                    w_wdata = w_mdu_res;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_valid     <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (w_we) begin
                r_valid[w_waddr] <= 1'b1;
            end
        end
        r_out_value <= n_out_value;
        r_out_err   <= n_out_err;
        if (r_state == S_IDLE) begin
            r_inst <= i_q_inst;
            r_rd_a <= r_mem[f_idx(i_q_inst.ra)];
            r_rd_b <= r_mem[f_idx(i_q_inst.rb)];
            r_va   <= r_valid[f_idx(i_q_inst.ra)];
            r_vb   <= r_valid[f_idx(i_q_inst.rb)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
    end

    rae_mdu #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_mdu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (w_mdu_req),
        .i_a      (w_a),
        .i_b      (w_b),
        .o_done   (w_mdu_done),
        .o_result (w_mdu_res)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_value = r_out_value;
    assign o_out_err   = r_out_err;

`ifndef SYNTHESIS
    a_done_in_mdu: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mdu_done |-> (r_state == S_MDU))
        else $error("mdu finished outside of its wait state");

    a_pop_when_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> i_q_valid)
        else $error("queue popped while empty");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_state != S_IDLE))
        else $error("register file written while idle");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_err) |-> (r_out_value == '0))
        else $error("error result carries a nonzero value");

    a_swap_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWAP) |-> ($past(r_state) == S_EXEC))
        else $error("exchange second write without first");
`endif

endmodule

`default_nettype wire

// File: bench/testbench.sv
// Self-checking bench for register_alu_executor_core: shadow register file predicts every emit.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 12;
    localparam int QUIET_LIMIT  = 4000;   // cycles with no handshake on either side
    localparam int DRAIN_CYCLES = 60;     // longer than a multiply/divide pass
    localparam int PHASE_ITEMS  = 425;

    localparam logic [31:0] MIN_VAL = 32'h8000_0000;
    localparam logic [31:0] MAX_VAL = 32'h7FFF_FFFF;
    localparam logic [31:0] ALL_ONE = 32'hFFFF_FFFF;

    // One pre-decoded instruction as it travels on the input stream
    typedef struct {
        logic [3:0]  kind;
        logic [1:0]  dest;
        logic [1:0]  src_a;
        logic [1:0]  src_b;
        logic [31:0] imm;
    } t_instr;

    // One emitted item: OUT value or divide fault
    typedef struct {
        logic [31:0] value;
        logic        fault;
    } t_emit;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    wire                            s_axis_tready;
    // [3:0] kind, [5:4] dest, [7:6] src_a, [9:8] src_b, [41:10] immediate, [47:42] zero
    logic [rae_pkg::IN_TDATA_W-1:0] s_axis_tdata = '0;
    wire                            m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    // [31:0] value
    wire  [rae_pkg::VALUE_W-1:0]    m_axis_tdata;
    // [0] error
    wire  [0:0]                     m_axis_tuser;

    logic [31:0] shadow_regs [4] = '{default: '0};
    t_emit       pending_emits [$];
    t_emit       oldest_emit;
    int          err_count = 0;
    int          quiet_cycles = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;

    register_alu_executor_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        err_count++;
        $display("[%0t] MISMATCH: %s", $time, what);
    endtask

    // Apply one instruction to the shadow register file; queue any emit it causes.
    function automatic void exec_instruction(input t_instr ins);
        logic [31:0]        a;
        logic [31:0]        b;
        logic [31:0]        tmp;
        logic signed [31:0] sa;
        logic signed [31:0] sb;
        a  = shadow_regs[ins.src_a];
        b  = shadow_regs[ins.src_b];
        sa = a;
        sb = b;
        case (ins.kind)
            rae_pkg::KIND_LOAD: shadow_regs[ins.dest] = ins.imm;
            rae_pkg::KIND_MOV:  shadow_regs[ins.dest] = a;
            rae_pkg::KIND_ADD:  shadow_regs[ins.dest] = a + b;
            rae_pkg::KIND_SUB:  shadow_regs[ins.dest] = a - b;
            rae_pkg::KIND_MUL:  shadow_regs[ins.dest] = a * b;
            rae_pkg::KIND_DIV, rae_pkg::KIND_MOD: begin
                // zero divisor or min / -1: keep dest, flag a fault
                if (b == '0 || (a == MIN_VAL && b == ALL_ONE)) begin
                    pending_emits.push_back('{value: '0, fault: 1'b1});
                end else if (ins.kind == rae_pkg::KIND_DIV) begin
                    shadow_regs[ins.dest] = sa / sb;
                end else begin
                    shadow_regs[ins.dest] = sa % sb;
                end
            end
            rae_pkg::KIND_AND:  shadow_regs[ins.dest] = a & b;
            rae_pkg::KIND_OR:   shadow_regs[ins.dest] = a | b;
            rae_pkg::KIND_XOR:  shadow_regs[ins.dest] = a ^ b;
            rae_pkg::KIND_XCHG: begin
                tmp = shadow_regs[ins.dest];
                shadow_regs[ins.dest]  = shadow_regs[ins.src_a];
                shadow_regs[ins.src_a] = tmp;
            end
            rae_pkg::KIND_OUT:  pending_emits.push_back('{value: a, fault: 1'b0});
            default: ;  // unused opcodes do nothing
        endcase
    endfunction

    function automatic t_instr make_instr(input logic [3:0] kind, input logic [1:0] dest,
                                          input logic [1:0] src_a, input logic [1:0] src_b,
                                          input logic [31:0] imm);
        t_instr ins;
        ins.kind  = kind;
        ins.dest  = dest;
        ins.src_a = src_a;
        ins.src_b = src_b;
        ins.imm   = imm;
        return ins;
    endfunction

    // Drive one item from a falling edge, idle at random first, hold until accepted.
    task automatic send_instruction(input t_instr ins);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, ins.imm, ins.src_b, ins.src_a, ins.dest, ins.kind};
        do @(posedge i_clk); while (!s_axis_tready);
        exec_instruction(ins);
    endtask

    // Mostly loads, outputs and ALU ops; a few unused opcodes as noise.
    function automatic t_instr random_instruction();
        t_instr ins;
        int     pick;
        pick = $urandom_range(99);
        if (pick < 3)
            ins.kind = 4'($urandom_range(12, 15));
        else if (pick < 20)
            ins.kind = rae_pkg::KIND_LOAD;
        else if (pick < 38)
            ins.kind = rae_pkg::KIND_OUT;
        else
            ins.kind = 4'($urandom_range(rae_pkg::KIND_MOV, rae_pkg::KIND_XCHG));
        ins.dest  = 2'($urandom);
        ins.src_a = 2'($urandom);
        ins.src_b = 2'($urandom);
        // favor corner values so faults and wraps show up often
        case ($urandom_range(7))
            0:       ins.imm = '0;
            1:       ins.imm = ALL_ONE;
            2:       ins.imm = MIN_VAL;
            3:       ins.imm = MAX_VAL;
            4:       ins.imm = 32'd1;
            5:       ins.imm = 32'($urandom_range(32)) - 32'd16;
            default: ins.imm = $urandom;
        endcase
        return ins;
    endfunction

    task automatic run_random(input int count, input int idle_pct, input int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count) send_instruction(random_instruction());
    endtask

    // Registers must read back as zero right after reset.
    task automatic test_reset_values();
        send_instruction(make_instr(rae_pkg::KIND_OUT, 2'd0, 2'd0, 2'd0, '0));
        send_instruction(make_instr(rae_pkg::KIND_OUT, 2'd0, 2'd3, 2'd0, '0));
    endtask

    // Touch every opcode but divide and modulo at least once, with wrapping operands and an unused code.
    task automatic test_every_opcode();
        send_instruction(make_instr(rae_pkg::KIND_LOAD, 2'd0, 2'd0, 2'd0, MAX_VAL));
        send_instruction(make_instr(rae_pkg::KIND_LOAD, 2'd1, 2'd0, 2'd0, MIN_VAL));
        send_instruction(make_instr(rae_pkg::KIND_ADD,  2'd2, 2'd0, 2'd1, '0));
        send_instruction(make_instr(rae_pkg::KIND_SUB,  2'd3, 2'd1, 2'd0, '0));
        send_instruction(make_instr(rae_pkg::KIND_MUL,  2'd0, 2'd0, 2'd3, '0));
        send_instruction(make_instr(rae_pkg::KIND_AND,  2'd3, 2'd2, 2'd1, '0));
        send_instruction(make_instr(rae_pkg::KIND_OR,   2'd1, 2'd1, 2'd0, '0));
        send_instruction(make_instr(rae_pkg::KIND_XOR,  2'd2, 2'd2, 2'd3, '0));
        send_instruction(make_instr(rae_pkg::KIND_MOV,  2'd3, 2'd1, 2'd0, '0));
        send_instruction(make_instr(rae_pkg::KIND_XCHG, 2'd0, 2'd2, 2'd0, '0));
        send_instruction(make_instr(4'hF,               2'd3, 2'd3, 2'd3, ALL_ONE));
        send_instruction(make_instr(rae_pkg::KIND_OUT,  2'd0, 2'd0, 2'd0, '0));
        send_instruction(make_instr(rae_pkg::KIND_OUT,  2'd0, 2'd2, 2'd0, '0));
        send_instruction(make_instr(rae_pkg::KIND_OUT,  2'd0, 2'd3, 2'd0, '0));
    endtask

    // Divide by zero and min / -1 on both div and mod, then signed truncation.
    task automatic test_divide_faults();
        send_instruction(make_instr(rae_pkg::KIND_LOAD, 2'd0, 2'd0, 2'd0, MIN_VAL));
        send_instruction(make_instr(rae_pkg::KIND_LOAD, 2'd1, 2'd0, 2'd0, ALL_ONE));
        send_instruction(make_instr(rae_pkg::KIND_LOAD, 2'd2, 2'd0, 2'd0, '0));
        send_instruction(make_instr(rae_pkg::KIND_LOAD, 2'd3, 2'd0, 2'd0, 32'hFFFF_FFF9));
        send_instruction(make_instr(rae_pkg::KIND_DIV,  2'd3, 2'd3, 2'd2, '0));
        send_instruction(make_instr(rae_pkg::KIND_MOD,  2'd3, 2'd3, 2'd2, '0));
        send_instruction(make_instr(rae_pkg::KIND_DIV,  2'd0, 2'd0, 2'd1, '0));
        send_instruction(make_instr(rae_pkg::KIND_MOD,  2'd0, 2'd0, 2'd1, '0));
        send_instruction(make_instr(rae_pkg::KIND_OUT,  2'd0, 2'd0, 2'd0, '0));
        send_instruction(make_instr(rae_pkg::KIND_DIV,  2'd1, 2'd3, 2'd1, '0));
        send_instruction(make_instr(rae_pkg::KIND_MOD,  2'd2, 2'd0, 2'd3, '0));
        send_instruction(make_instr(rae_pkg::KIND_OUT,  2'd0, 2'd1, 2'd0, '0));
        send_instruction(make_instr(rae_pkg::KIND_OUT,  2'd0, 2'd2, 2'd0, '0));
    endtask

    task automatic test_random_no_idle();
        run_random(PHASE_ITEMS, 0, 0);
    endtask

    task automatic test_random_sender_idle();
        run_random(PHASE_ITEMS, 80, 0);
    endtask

    task automatic test_random_receiver_stall();
        run_random(PHASE_ITEMS, 0, 80);
    endtask

    task automatic test_random_both_idle();
        run_random(PHASE_ITEMS, 38, 38);
    endtask

    // Stall the output side at random, changing only on the falling edge.
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Compare each accepted output item with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_emits.size() == 0) begin
                report_mismatch($sformatf("unexpected item value=%h error=%b",
                                          m_axis_tdata, m_axis_tuser[0]));
            end else begin
                oldest_emit = pending_emits.pop_front();
                if (m_axis_tdata !== oldest_emit.value)
                    report_mismatch($sformatf("value %h, expected %h",
                                              m_axis_tdata, oldest_emit.value));
                if (m_axis_tuser[0] !== oldest_emit.fault)
                    report_mismatch($sformatf("error %b, expected %b",
                                              m_axis_tuser[0], oldest_emit.fault));
            end
        end
    end

    // End the run if neither side moves an item for too long.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_values();
        test_every_opcode();
        test_divide_faults();
        test_random_no_idle();
        test_random_sender_idle();
        test_random_receiver_stall();
        test_random_both_idle();

        // drop valid, drain outstanding emits, then watch for strays
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_emits.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
